// ----- design/dmlb_pkg.sv -----
// ----------------------------------------------------------------------------
// dmlb_pkg
// Shared widths, operation codes and result types of the direct-mapped line
// buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package dmlb_pkg;

	localparam int ADDR_W    = 48;
	localparam int FUNC_W    = 2;
	localparam int WIDX_W    = 3;
	localparam int WORD_W    = 64;
	localparam int CNT_W     = 32;
	localparam int MAX_WORDS = 8;

	localparam int DEF_ENTRIES    = 64;
	localparam int DEF_LINE_BYTES = 64;
	localparam int DEF_ADDR_BITS  = 48;

	// stream word layouts
	localparam int S_TDATA_W = 120;
	localparam int M_TDATA_W = 192;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOOKUP = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_INSERT = 2'd2,
		FUNC_INVAL  = 2'd3
	} func_t;

	typedef struct packed {
		logic [CNT_W-1:0] insert_count;
		logic [CNT_W-1:0] miss_count;
		logic [CNT_W-1:0] hit_count;
		logic [CNT_W-1:0] access_count;
	} counts_t;

	typedef struct packed {
		logic              hit;
		logic [WORD_W-1:0] line_word;
		logic              last;
		counts_t           counts;
	} result_t;

	// per-item request toward the tag store, all sampled at acceptance
	typedef struct packed {
		logic accept;
		logic insert;
		logic inval;
	} tag_req_t;

endpackage

`default_nettype wire

// ----- design/dmlb_tag_store.sv -----
// ----------------------------------------------------------------------------
// dmlb_tag_store
// Tag memory and valid bits. Reads and writes happen at item acceptance; the
// hit flag of the accepted item is formed from the registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dmlb_tag_store #(
	parameter int ENTRIES = 64,
	parameter int IDX_W   = 6,
	parameter int TAG_W   = 36
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dmlb_pkg::tag_req_t req,
	input  logic [IDX_W-1:0]   idx,
	input  logic [TAG_W-1:0]   tag,
	output logic               hit
);
	import dmlb_pkg::*;

	logic [TAG_W-1:0]   tag_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_bits_q;
	logic [TAG_W-1:0]   tag_rd_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic               valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_bits_q <= '0;
		end else if (req.accept) begin
			if (req.inval) begin
				valid_bits_q <= '0;
			end else if (req.insert) begin
				valid_bits_q[idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.accept) begin
			tag_rd_s1 <= tag_mem[idx];
			tag_s1    <= tag;
			valid_s1  <= valid_bits_q[idx];
			if (req.insert) begin
				tag_mem[idx] <= tag;
			end
		end
	end

	assign hit = valid_s1 && (tag_rd_s1 == tag_s1);

	a_inval_clears: assert property (@(posedge clk) disable iff (!arst_n)
		req.accept && req.inval |=> valid_bits_q == '0)
		else $error("valid bits remain after invalidate-all");

endmodule

`default_nettype wire

// ----- design/dmlb_line_store.sv -----
// ----------------------------------------------------------------------------
// dmlb_line_store
// Line data memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dmlb_line_store #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [dmlb_pkg::WORD_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [dmlb_pkg::WORD_W-1:0] rd_data
);
	import dmlb_pkg::*;

	logic [WORD_W-1:0] line_mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_addr] <= wr_data;
		end
	end

	// hold read data while the result side stalls
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= line_mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- design/dmlb_seq.sv -----
// ----------------------------------------------------------------------------
// dmlb_seq
// Operation stage, lookup and insert counters and result register. A read hit
// stays in the stage and streams one line word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dmlb_seq #(
	parameter int NWORDS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  dmlb_pkg::func_t             in_func,
	input  logic                        hit,
	input  logic [dmlb_pkg::WORD_W-1:0] rd_data,
	input  logic                        out_ready,
	output logic                        in_ready,
	output logic                        accept,
	output logic                        rd_next,
	output logic [dmlb_pkg::WIDX_W-1:0] rd_word,
	output logic                        out_valid,
	output dmlb_pkg::result_t           out_res
);
	import dmlb_pkg::*;

	localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NWORDS - 1);

	logic              valid_s1;
	func_t             func_s1;
	logic [WIDX_W-1:0] word_q;
	counts_t           cnt_q;
	counts_t           cnt_n;
	logic              out_valid_q;
	result_t           res_q;
	result_t           res_n;
	logic              out_free;
	logic              emit;
	logic              read_hit;
	logic              s1_last;
	logic              s1_done;

	assign out_free = !out_valid_q || out_ready;
	assign emit     = valid_s1 && out_free;
	assign read_hit = (func_s1 == FUNC_READ) && hit;
	assign s1_last  = !read_hit || (word_q == LAST_WORD);
	assign s1_done  = emit && s1_last;
	assign in_ready = !valid_s1 || s1_done;
	assign accept   = in_valid && in_ready;
	assign rd_next  = emit && !s1_last;
	assign rd_word  = word_q + WIDX_W'(1);

	always_comb begin
		cnt_n = cnt_q;
		case (func_s1)
			FUNC_LOOKUP: begin
				cnt_n.access_count = cnt_q.access_count + CNT_W'(1);
				if (hit) begin
					cnt_n.hit_count = cnt_q.hit_count + CNT_W'(1);
				end else begin
					cnt_n.miss_count = cnt_q.miss_count + CNT_W'(1);
				end
			end
			FUNC_INSERT: begin
				cnt_n.insert_count = cnt_q.insert_count + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_n.hit       = ((func_s1 == FUNC_LOOKUP) || (func_s1 == FUNC_READ)) && hit;
		res_n.line_word = read_hit ? rd_data : '0;
		res_n.last      = s1_last;
		res_n.counts    = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			word_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				word_q   <= '0;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end else if (rd_next) begin
				word_q <= rd_word;
			end
			if (emit) begin
				cnt_q       <= cnt_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= in_func;
		end
		if (emit) begin
			res_q <= res_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	a_no_accept_midstream: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_last |-> !in_ready)
		else $error("input accepted while a line is still streaming");

	a_word_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> word_q <= LAST_WORD)
		else $error("line word position past the streamed length");

	a_stream_continues: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !s1_last |=> valid_s1)
		else $error("operation dropped before its final word");

	a_counts_balance: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q.access_count == CNT_W'(cnt_q.hit_count + cnt_q.miss_count))
		else $error("lookup count differs from hits plus misses");

endmodule

`default_nettype wire

// ----- design/direct_mapped_line_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_line_buffer_unit
// Direct-mapped instruction line buffer: lookup, read line, insert word and
// invalidate-all, with wrapping lookup and insert counters.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser func, tdata addr/word_index/data_word
//   m_*      out  m_tvalid/m_tready  tuser hit, tlast last, tdata word + counts
//
// Lookup, insert and invalidate-all leave the operation stage as their result is
// taken; one can enter per cycle unless the result stalls. A read hit streams
// min(LINE_BYTES/8, 8) words, one per cycle unless stalled, via the line memory's
// single read port. Results pass the operation stage, then the result register.
// Reset clears the valid bits and counters at once; no clearing pass is needed.
// A stalled result holds the result register and the operation stage in place.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_line_buffer_unit #(
	parameter int ENTRIES    = dmlb_pkg::DEF_ENTRIES,
	parameter int LINE_BYTES = dmlb_pkg::DEF_LINE_BYTES,
	parameter int ADDR_BITS  = dmlb_pkg::DEF_ADDR_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// addr [47:0], word_index [50:48], data_word [114:51], zero [119:115]
	input  logic [dmlb_pkg::S_TDATA_W-1:0] s_tdata,
	// func [1:0]
	input  logic [dmlb_pkg::FUNC_W-1:0]    s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// line_word [63:0], access_count [95:64], hit_count [127:96],
	// miss_count [159:128], insert_count [191:160]
	output logic [dmlb_pkg::M_TDATA_W-1:0] m_tdata,
	// hit [0]
	output logic                           m_tuser,
	output logic                           m_tlast
);
	import dmlb_pkg::*;

	localparam int OFF_W   = $clog2(LINE_BYTES);
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int EFF_W   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int TAG_RAW = EFF_W - OFF_W - IDX_W;
	localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int WORDS   = LINE_BYTES / 8;
	localparam int WOFF_W  = $clog2(WORDS);
	localparam int NWORDS  = (WORDS < MAX_WORDS) ? WORDS : MAX_WORDS;
	localparam int LA_W    = IDX_W + WOFF_W;
	localparam int DEPTH   = ENTRIES * WORDS;
	localparam logic [ADDR_W-1:0] KEEP_MASK = {ADDR_W{1'b1}} >> (ADDR_W - EFF_W);

	logic [ADDR_W-1:0] in_addr;
	logic [WIDX_W-1:0] in_widx;
	logic [WORD_W-1:0] in_data;
	func_t             in_func;
	logic [ADDR_W-1:0] addr_k;
	logic [IDX_W-1:0]  idx;
	logic [TAG_W-1:0]  tag;
	logic [IDX_W-1:0]  idx_s1;
	logic              accept;
	logic              in_ready;
	logic              hit;
	logic              rd_next;
	logic [WIDX_W-1:0] rd_word;
	logic [WORD_W-1:0] rd_data;
	logic              line_wr;
	logic [LA_W-1:0]   line_wr_addr;
	logic [LA_W-1:0]   line_rd_addr;
	logic [IDX_W-1:0]  rd_idx;
	logic [WIDX_W-1:0] rd_off;
	tag_req_t          tag_req;
	result_t           res;

	assign in_addr = s_tdata[47:0];
	assign in_widx = s_tdata[50:48];
	assign in_data = s_tdata[114:51];
	assign in_func = func_t'(s_tuser);

	// drop address bits above the kept width, then split offset / index / tag
	assign addr_k = in_addr & KEEP_MASK;
	assign idx    = IDX_W'(addr_k >> OFF_W);
	assign tag    = TAG_W'(addr_k >> (OFF_W + IDX_W));

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= idx;
		end
	end

	assign tag_req.accept = accept;
	assign tag_req.insert = (in_func == FUNC_INSERT);
	assign tag_req.inval  = (in_func == FUNC_INVAL);

	// word positions past the line end set tag and valid but write no data
	assign line_wr      = accept && (in_func == FUNC_INSERT) && (32'(in_widx) < 32'(WORDS));
	assign line_wr_addr = (LA_W'(idx) << WOFF_W) | LA_W'(in_widx);
	assign rd_idx       = accept ? idx : idx_s1;
	assign rd_off       = accept ? '0 : rd_word;
	assign line_rd_addr = (LA_W'(rd_idx) << WOFF_W) | LA_W'(rd_off);

	dmlb_tag_store #(
		.ENTRIES(ENTRIES),
		.IDX_W  (IDX_W),
		.TAG_W  (TAG_W)
	) u_tag_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (tag_req),
		.idx   (idx),
		.tag   (tag),
		.hit   (hit)
	);

	dmlb_line_store #(
		.DEPTH(DEPTH),
		.AW   (LA_W)
	) u_line_store (
		.clk    (clk),
		.wr_en  (line_wr),
		.wr_addr(line_wr_addr),
		.wr_data(in_data),
		.rd_en  (accept || rd_next),
		.rd_addr(line_rd_addr),
		.rd_data(rd_data)
	);

	dmlb_seq #(
		.NWORDS(NWORDS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_func  (in_func),
		.hit      (hit),
		.rd_data  (rd_data),
		.out_ready(m_tready),
		.in_ready (in_ready),
		.accept   (accept),
		.rd_next  (rd_next),
		.rd_word  (rd_word),
		.out_valid(m_tvalid),
		.out_res  (res)
	);

	assign s_tready = in_ready;
	assign m_tdata  = {res.counts.insert_count, res.counts.miss_count, res.counts.hit_count,
		res.counts.access_count, res.line_word};
	assign m_tuser  = res.hit;
	assign m_tlast  = res.last;

endmodule

`default_nettype wire
